/* hw/rtl/tsdc_pkg.sv */
// Shared types and constants for the tagged scatter unit with duplicate check.
// No dependencies; every other file imports this package.
package tsdc_pkg;

  localparam int DEF_ROWS      = 256;
  localparam int DEF_MAX_WIDTH = 8;

  localparam int TAG_W    = 8;
  localparam int ROWCNT_W = 9;
  localparam int ROWWID_W = 4;
  localparam int RIDX_W   = 33;
  localparam int POS_W    = 3;
  localparam int WORD_W   = 64;
  localparam int STAT_W   = 3;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_SOURCE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_TOO_BIG  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NEGATIVE = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP      = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 3'd4;

  localparam logic [1:0] REG_SEL_TAG   = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_ROW_WIDTH = 2'd2;

  typedef struct packed {
    logic signed [TAG_W-1:0] selected_tag;
    logic [ROWCNT_W-1:0]     row_count;
    logic [ROWWID_W-1:0]     row_width;
  } cfg_t;

endpackage

/* hw/rtl/tagged_scatter_with_duplicate_check_unit.sv */
// Tagged scatter with duplicate check: takes one command beat per cycle unless
// out_ready stalls the result register behind the check-and-write stage, which
// takes the table memory's registered read and forwards its write to a following
// read of the same word. Clear flash-clears the row valid bits. Configure only
// while no beat is in flight. Depends on tsdc_pkg.
module tagged_scatter_with_duplicate_check_unit #(
  parameter int ROWS      = tsdc_pkg::DEF_ROWS,
  parameter int MAX_WIDTH = tsdc_pkg::DEF_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tsdc_pkg::PADDR_W-1:0]         paddr,
  input  logic [tsdc_pkg::PDATA_W-1:0]         pwdata,
  output logic [tsdc_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           cmd,
  input  logic signed [tsdc_pkg::TAG_W-1:0]    tag,
  input  logic signed [tsdc_pkg::RIDX_W-1:0]   row_index,
  input  logic [tsdc_pkg::POS_W-1:0]           word_pos,
  input  logic signed [tsdc_pkg::WORD_W-1:0]   id_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tsdc_pkg::STAT_W-1:0]          status,
  output logic signed [tsdc_pkg::WORD_W-1:0]   read_word,
  output logic                                 unique_flag
);
  import tsdc_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = ROWS * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t              cfg;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [WORD_W-1:0] mem_rd_data;

  assign pready = 1'b1;

  tsdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  tsdc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tsdc_core #(
    .ROWS      (ROWS),
    .MAX_WIDTH (MAX_WIDTH),
    .RW        (RW),
    .AW        (AW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .tag         (tag),
    .row_index   (row_index),
    .word_pos    (word_pos),
    .id_word     (id_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_word   (read_word),
    .unique_flag (unique_flag),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

endmodule

/* hw/rtl/tsdc_regs.sv */
// APB-style configuration registers: selected tag, row count, row width.
// Depends on tsdc_pkg.
module tsdc_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsdc_pkg::PADDR_W-1:0]    paddr,
  input  logic [tsdc_pkg::PDATA_W-1:0]    pwdata,
  output logic [tsdc_pkg::PDATA_W-1:0]    prdata,
  output tsdc_pkg::cfg_t                  cfg
);
  import tsdc_pkg::*;

  logic       wr;
  logic [1:0] idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.selected_tag <= '0;
      cfg.row_count    <= '0;
      cfg.row_width    <= ROWWID_W'(1);
    end else if (wr) begin
      case (idx)
        REG_SEL_TAG:   cfg.selected_tag <= pwdata[TAG_W-1:0];
        REG_ROW_COUNT: cfg.row_count    <= pwdata[ROWCNT_W-1:0];
        REG_ROW_WIDTH: cfg.row_width    <= pwdata[ROWWID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEL_TAG:   prdata = PDATA_W'(cfg.selected_tag);
      REG_ROW_COUNT: prdata = PDATA_W'(cfg.row_count);
      REG_ROW_WIDTH: prdata = PDATA_W'(cfg.row_width);
      default:       prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/tsdc_mem.sv */
// Identity word table: one write port, one read port, registered read data.
// Depends on tsdc_pkg for the word width.
module tsdc_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [tsdc_pkg::WORD_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [tsdc_pkg::WORD_W-1:0]    rd_data
);
  import tsdc_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/tsdc_core.sv */
// Check-and-scatter stage: run state, row valid bits, table write-back with
// forwarding, and the result register. Depends on tsdc_pkg.
module tsdc_core #(
  parameter int ROWS      = tsdc_pkg::DEF_ROWS,
  parameter int MAX_WIDTH = tsdc_pkg::DEF_MAX_WIDTH,
  parameter int RW        = (ROWS > 1) ? $clog2(ROWS) : 1,
  parameter int AW        = (ROWS * MAX_WIDTH > 1) ? $clog2(ROWS * MAX_WIDTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tsdc_pkg::cfg_t                       cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           cmd,
  input  logic signed [tsdc_pkg::TAG_W-1:0]    tag,
  input  logic signed [tsdc_pkg::RIDX_W-1:0]   row_index,
  input  logic [tsdc_pkg::POS_W-1:0]           word_pos,
  input  logic signed [tsdc_pkg::WORD_W-1:0]   id_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tsdc_pkg::STAT_W-1:0]          status,
  output logic signed [tsdc_pkg::WORD_W-1:0]   read_word,
  output logic                                 unique_flag,
  output logic                                 mem_wr_en,
  output logic [AW-1:0]                        mem_wr_addr,
  output logic [tsdc_pkg::WORD_W-1:0]          mem_wr_data,
  output logic                                 mem_rd_en,
  output logic [AW-1:0]                        mem_rd_addr,
  input  logic [tsdc_pkg::WORD_W-1:0]          mem_rd_data
);
  import tsdc_pkg::*;

  logic                s_valid;
  cmd_t                s_cmd;
  logic [TAG_W-1:0]    s_tag;
  logic [RIDX_W-1:0]   s_ridx;
  logic [POS_W-1:0]    s_pos;
  logic [WORD_W-1:0]   s_word;
  logic                fwd_hit;
  logic [WORD_W-1:0]   fwd_data;

  logic [ROWS-1:0]     row_valid;
  logic [STAT_W-1:0]   sticky;
  logic                item_acc;
  logic [RW-1:0]       cur_row;

  logic                s_go;
  logic                accept;
  logic [RW-1:0]       s_row;
  logic [WORD_W-1:0]   mem_q;
  logic                in_rows;
  logic [ROWWID_W-1:0] wid_eff;
  logic                pos_ok;
  logic [WORD_W-1:0]   first;
  logic [RW-1:0]       wr_row;

  logic [STAT_W-1:0]   res_status;
  logic [WORD_W-1:0]   res_word;
  logic                res_uniq;
  logic [STAT_W-1:0]   sticky_next;
  logic                item_acc_next;
  logic [RW-1:0]       cur_row_next;
  logic                set_valid;
  logic                clr_valid;

  assign s_go     = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || s_go;
  assign accept   = in_valid && in_ready;

  assign mem_rd_en   = accept;
  assign mem_rd_addr = AW'(AW'(row_index[RW-1:0]) * AW'(MAX_WIDTH)
                           + ((cmd == CMD_READ) ? AW'(word_pos) : AW'(0)));

  assign s_row   = s_ridx[RW-1:0];
  assign mem_q   = fwd_hit ? fwd_data : mem_rd_data;
  assign in_rows = !s_ridx[RIDX_W-1]
                   && (s_ridx[31:0] < 32'(cfg.row_count))
                   && (s_ridx[31:0] < 32'(ROWS));
  assign wid_eff = (cfg.row_width == '0) ? ROWWID_W'(1) : cfg.row_width;
  assign pos_ok  = (ROWWID_W'(s_pos) < wid_eff) && (32'(s_pos) < 32'(MAX_WIDTH));
  assign first   = row_valid[s_row] ? mem_q : ALL_ONES;

  assign wr_row      = (s_pos == '0) ? s_row : cur_row;
  assign mem_wr_addr = AW'(AW'(wr_row) * AW'(MAX_WIDTH) + AW'(s_pos));
  assign mem_wr_data = s_word;

  always_comb begin
    res_status    = ST_OK;
    res_word      = '0;
    res_uniq      = 1'b0;
    sticky_next   = sticky;
    item_acc_next = item_acc;
    cur_row_next  = cur_row;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    mem_wr_en     = 1'b0;
    case (s_cmd)
      CMD_CLEAR: begin
        clr_valid     = 1'b1;
        sticky_next   = ST_OK;
        item_acc_next = 1'b0;
        cur_row_next  = '0;
      end
      CMD_SOURCE: begin
        if (sticky != ST_OK) begin
          res_status = ST_IGNORED;
        end else if (s_tag != cfg.selected_tag) begin
          if (s_pos == '0) begin
            item_acc_next = 1'b0;
          end
        end else if (s_pos == '0) begin
          item_acc_next = 1'b0;
          if (s_ridx[RIDX_W-1]) begin
            res_status  = ST_NEGATIVE;
            sticky_next = ST_NEGATIVE;
          end else if (!in_rows) begin
            res_status  = ST_TOO_BIG;
            sticky_next = ST_TOO_BIG;
          end else if (first != ALL_ONES) begin
            res_status  = ST_DUP;
            sticky_next = ST_DUP;
          end else begin
            mem_wr_en     = s_valid;
            set_valid     = 1'b1;
            item_acc_next = 1'b1;
            cur_row_next  = s_row;
          end
        end else if (item_acc && pos_ok) begin
          mem_wr_en = s_valid;
        end
      end
      CMD_READ: begin
        res_status = sticky;
        res_word   = (in_rows && pos_ok && row_valid[s_row]) ? mem_q : ALL_ONES;
      end
      CMD_FINISH: begin
        res_status = sticky;
        res_uniq   = (sticky == ST_OK);
      end
      default: ;
    endcase
    if (!s_go) begin
      mem_wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= 1'b0;
      out_valid <= 1'b0;
      row_valid <= '0;
      sticky    <= ST_OK;
      item_acc  <= 1'b0;
      cur_row   <= '0;
      fwd_hit   <= 1'b0;
    end else begin
      if (accept) begin
        s_valid <= 1'b1;
        fwd_hit <= mem_wr_en && (mem_wr_addr == mem_rd_addr);
      end else if (s_go) begin
        s_valid <= 1'b0;
      end
      if (s_go) begin
        out_valid <= 1'b1;
        sticky    <= sticky_next;
        item_acc  <= item_acc_next;
        cur_row   <= cur_row_next;
        if (clr_valid) begin
          row_valid <= '0;
        end else if (set_valid) begin
          row_valid[s_row] <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_cmd    <= cmd_t'(cmd);
      s_tag    <= tag;
      s_ridx   <= row_index;
      s_pos    <= word_pos;
      s_word   <= id_word;
      fwd_data <= mem_wr_data;
    end
    if (s_go) begin
      status      <= res_status;
      read_word   <= res_word;
      unique_flag <= res_uniq;
    end
  end

endmodule

/* test/tb_tagged_scatter_with_duplicate_check_unit.sv */
// Self-checking bench for the tagged scatter unit with duplicate check: a directed
// pass over the special cases, then random scatter runs with and without stalls.
// Depends on tsdc_pkg and tagged_scatter_with_duplicate_check_unit.
module tb_tagged_scatter_with_duplicate_check_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tsdc_pkg::*;

  localparam int TBL_ROWS    = 256;
  localparam int TBL_COLS    = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    cmd_t        op;
    logic [7:0]  tag;
    logic [32:0] ridx;
    logic [2:0]  pos;
    logic [63:0] word;
  } beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] word;
    logic        uniq;
  } result_t;

  logic                        clk;
  logic                        rst;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [PADDR_W-1:0]          paddr;
  logic [PDATA_W-1:0]          pwdata;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_ready;
  logic [1:0]                  cmd;
  logic signed [TAG_W-1:0]     tag;
  logic signed [RIDX_W-1:0]    row_index;
  logic [POS_W-1:0]            word_pos;
  logic signed [WORD_W-1:0]    id_word;
  logic                        out_valid;
  logic                        out_ready;
  logic [STAT_W-1:0]           status;
  logic signed [WORD_W-1:0]    read_word;
  logic                        unique_flag;

  // predicted contents of the block
  logic [63:0] tbl_mem     [TBL_ROWS*TBL_COLS];
  bit          tbl_written [TBL_ROWS*TBL_COLS];
  bit          row_live    [TBL_ROWS];
  logic [2:0]  run_status;
  bit          row_open;
  logic [7:0]  open_row;
  logic [7:0]  tag_sel;
  logic [8:0]  rows_used;
  logic [3:0]  words_per_row;

  result_t pending_results[$];
  result_t want_now;
  int      mismatches;
  int      beats_sent;
  int      quiet_cycles;
  bit      idle_on;

  tagged_scatter_with_duplicate_check_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .tag         (tag),
    .row_index   (row_index),
    .word_pos    (word_pos),
    .id_word     (id_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_word   (read_word),
    .unique_flag (unique_flag)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic int rows_in_use();
    return (rows_used > 9'(TBL_ROWS)) ? TBL_ROWS : int'(rows_used);
  endfunction

  function automatic int words_in_use();
    if (words_per_row == 4'd0) begin
      return 1;
    end
    return (words_per_row > 4'(TBL_COLS)) ? TBL_COLS : int'(words_per_row);
  endfunction

  function automatic beat_t make_beat(cmd_t op, logic [7:0] t, logic [32:0] r,
                                      logic [2:0] p, logic [63:0] w);
    beat_t b;
    b.op   = op;
    b.tag  = t;
    b.ridx = r;
    b.pos  = p;
    b.word = w;
    return b;
  endfunction

  function automatic result_t predict_scatter_result(beat_t b);
    result_t r;
    int      row;
    int      slot;
    r = '0;
    case (b.op)
      CMD_CLEAR: begin
        foreach (row_live[i]) row_live[i] = 1'b0;
        run_status = ST_OK;
        row_open   = 1'b0;
        open_row   = '0;
      end
      CMD_SOURCE: begin
        if (run_status != ST_OK) begin
          r.status = ST_IGNORED;
        end else if (b.tag != tag_sel) begin
          if (b.pos == 3'd0) row_open = 1'b0;
        end else if (b.pos == 3'd0) begin
          row_open = 1'b0;
          if (b.ridx[32]) begin
            r.status   = ST_NEGATIVE;
            run_status = ST_NEGATIVE;
          end else if (b.ridx >= 33'(rows_in_use())) begin
            r.status   = ST_TOO_BIG;
            run_status = ST_TOO_BIG;
          end else begin
            row  = int'(b.ridx[7:0]);
            slot = row * TBL_COLS;
            if (row_live[row] && tbl_mem[slot] != ALL_ONES) begin
              r.status   = ST_DUP;
              run_status = ST_DUP;
            end else begin
              tbl_mem[slot]     = b.word;
              tbl_written[slot] = 1'b1;
              row_live[row]     = 1'b1;
              row_open          = 1'b1;
              open_row          = b.ridx[7:0];
            end
          end
        end else if (row_open && int'(b.pos) < words_in_use()) begin
          slot = int'(open_row) * TBL_COLS + int'(b.pos);
          tbl_mem[slot]     = b.word;
          tbl_written[slot] = 1'b1;
        end
      end
      CMD_READ: begin
        r.status = run_status;
        r.word   = ALL_ONES;
        if (!b.ridx[32] && b.ridx < 33'(rows_in_use()) && int'(b.pos) < words_in_use()) begin
          row = int'(b.ridx[7:0]);
          if (row_live[row]) r.word = tbl_mem[row * TBL_COLS + int'(b.pos)];
        end
      end
      default: begin
        r.status = run_status;
        r.uniq   = (run_status == ST_OK);
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(beat_t b);
    beat_t item;
    int    slot;
    item = b;
    // steer reads away from words of a live row that were never stored
    if (item.op == CMD_READ && !item.ridx[32] && item.ridx < 33'(rows_in_use()) &&
        int'(item.pos) < words_in_use()) begin
      slot = int'(item.ridx[7:0]) * TBL_COLS + int'(item.pos);
      if (row_live[int'(item.ridx[7:0])] && !tbl_written[slot]) item.pos = 3'd0;
    end
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= item.op;
    tag       <= item.tag;
    row_index <= item.ridx;
    word_pos  <= item.pos;
    id_word   <= item.word;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_scatter_result(item));
    beats_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SEL_TAG:   tag_sel       = value[7:0];
      REG_ROW_COUNT: rows_used     = value[8:0];
      REG_ROW_WIDTH: words_per_row = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] t, logic [8:0] rows, logic [3:0] width);
    wait_idle();
    write_reg(REG_SEL_TAG, 32'(t));
    write_reg(REG_ROW_COUNT, 32'(rows));
    write_reg(REG_ROW_WIDTH, 32'(width));
  endtask

  task automatic test_reset_defaults();
    send_beat(make_beat(CMD_SOURCE, 8'd0, 33'd0, 3'd0, 64'd5));
    send_beat(make_beat(CMD_READ, 8'd0, 33'd0, 3'd0, 64'd0));
    send_beat(make_beat(CMD_FINISH, 8'd0, 33'd0, 3'd0, 64'd0));
  endtask

  task automatic test_full_width_row();
    set_config(8'h80, 9'd256, 4'd8);
    send_beat(make_beat(CMD_CLEAR, 8'h80, 33'd0, 3'd0, 64'd0));
    send_beat(make_beat(CMD_SOURCE, 8'h80, 33'd255, 3'd0, 64'h7fff_ffff_ffff_ffff));
    send_beat(make_beat(CMD_SOURCE, 8'h80, 33'd255, 3'd7, 64'h8000_0000_0000_0000));
    send_beat(make_beat(CMD_READ, 8'h80, 33'd255, 3'd7, 64'd0));
    send_beat(make_beat(CMD_READ, 8'h80, 33'd256, 3'd0, 64'd0));
    send_beat(make_beat(CMD_FINISH, 8'h80, 33'd0, 3'd0, 64'd0));
  endtask

  task automatic test_special_cases();
    set_config(8'h7f, 9'd3, 4'd2);
    send_beat(make_beat(CMD_CLEAR, 8'h7f, 33'd0, 3'd0, 64'd0));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd0, 3'd0, ALL_ONES));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd0, 3'd1, 64'h0123_4567_89ab_cdef));
    // tag mismatch at word 0 closes the row, so the next word is dropped
    send_beat(make_beat(CMD_SOURCE, 8'h00, 33'd1, 3'd0, 64'd11));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd0, 3'd1, 64'd22));
    send_beat(make_beat(CMD_READ, 8'h7f, 33'd0, 3'd1, 64'd0));
    // first word holds -1, so the row may be taken again
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd0, 3'd0, 64'd9));
    send_beat(make_beat(CMD_READ, 8'h7f, 33'd0, 3'd3, 64'd0));
    send_beat(make_beat(CMD_READ, 8'h7f, 33'h1_ffff_ffff, 3'd0, 64'd0));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd0, 3'd0, 64'd10));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd2, 3'd0, 64'd12));
    send_beat(make_beat(CMD_FINISH, 8'h7f, 33'd0, 3'd0, 64'd0));
  endtask

  task automatic test_error_status();
    send_beat(make_beat(CMD_CLEAR, 8'h7f, 33'd0, 3'd0, 64'd0));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'h1_0000_0000, 3'd0, 64'd1));
    send_beat(make_beat(CMD_CLEAR, 8'h7f, 33'd0, 3'd0, 64'd0));
    send_beat(make_beat(CMD_SOURCE, 8'h7f, 33'd3, 3'd0, 64'd1));
  endtask

  task automatic random_run();
    logic [7:0]  t;
    logic [8:0]  rows;
    logic [3:0]  width;
    logic [32:0] r;
    logic [63:0] w;
    int          steps;
    int          done;
    int          k;
    int          p;
    int          n;
    case ($urandom_range(0, 5))
      0:       t = 8'h80;
      1:       t = 8'h7f;
      default: t = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       rows = 9'd0;
      1:       rows = 9'd256;
      2:       rows = 9'd255;
      default: rows = 9'($urandom_range(1, 24));
    endcase
    width = 4'($urandom_range(1, 8));
    set_config(t, rows, width);
    send_beat(make_beat(CMD_CLEAR, tag_sel, 33'd0, 3'd0, 64'd0));
    steps = $urandom_range(20, 80);
    done  = 0;
    while (done < steps) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        p = $urandom_range(0, 99);
        if (p < 2) begin
          r = {1'b1, 32'($urandom)};
        end else if (p < 4 || rows_in_use() == 0) begin
          r = 33'(rows_in_use() + $urandom_range(0, 300));
        end else begin
          r = 33'($urandom_range(0, rows_in_use() - 1));
          for (int i = 0; i < 8 && p >= 7 && row_live[int'(r[7:0])]; i++) begin
            r = 33'($urandom_range(0, rows_in_use() - 1));
          end
        end
        n = words_in_use() + (($urandom_range(0, 9) == 0) ? 1 : 0);
        if (n > TBL_COLS) n = TBL_COLS;
        for (int pos = 0; pos < n; pos++) begin
          w = ($urandom_range(0, 19) == 0) ? ALL_ONES : {$urandom, $urandom};
          t = ($urandom_range(0, 19) == 0) ? 8'($urandom) : tag_sel;
          send_beat(make_beat(CMD_SOURCE, t, r, 3'(pos), w));
        end
        done += n;
      end else if (k < 75) begin
        if ($urandom_range(0, 9) == 0) begin
          r = {1'($urandom_range(0, 1)), 32'($urandom)};
        end else begin
          r = 33'($urandom_range(0, rows_in_use() + 1));
        end
        send_beat(make_beat(CMD_READ, 8'($urandom), r, 3'($urandom_range(0, 7)),
                            {$urandom, $urandom}));
        done++;
      end else if (k < 92) begin
        send_beat(make_beat(($urandom_range(0, 3) == 0) ? cmd_t'($urandom_range(0, 3))
                                                         : CMD_SOURCE,
                            ($urandom_range(0, 1) == 0) ? tag_sel : 8'($urandom),
                            {1'($urandom_range(0, 1)), 32'($urandom)},
                            3'($urandom_range(0, 7)), {$urandom, $urandom}));
        done++;
      end else begin
        send_beat(make_beat(CMD_FINISH, 8'($urandom), 33'd0, 3'd0, 64'd0));
        done++;
      end
    end
    send_beat(make_beat(CMD_FINISH, tag_sel, 33'd0, 3'd0, 64'd0));
  endtask

  task automatic test_random_runs();
    while (beats_sent < 1750) begin
      idle_on = ($urandom_range(0, 3) != 0);
      random_run();
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    while (beats_sent < 1900) random_run();
  endtask

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      int n;
      n = $urandom_range(1, 10);
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("unexpected result beat: status %0d read_word %h unique_flag %0b",
                   status, read_word, unique_flag);
        end
      end else begin
        want_now = pending_results.pop_front();
        if (status !== want_now.status || read_word !== want_now.word ||
            unique_flag !== want_now.uniq) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("result mismatch: status %0d/%0d read_word %h/%h unique_flag %0b/%0b",
                     want_now.status, status, want_now.word, read_word,
                     want_now.uniq, unique_flag);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tagged_scatter_with_duplicate_check_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    cmd           = CMD_CLEAR;
    tag           = '0;
    row_index     = '0;
    word_pos      = '0;
    id_word       = '0;
    mismatches    = 0;
    beats_sent    = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    run_status    = ST_OK;
    row_open      = 1'b0;
    open_row      = '0;
    tag_sel       = '0;
    rows_used     = '0;
    words_per_row = 4'd1;
    foreach (row_live[i]) row_live[i] = 1'b0;
    foreach (tbl_written[i]) tbl_written[i] = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_full_width_row();
    test_special_cases();
    test_error_status();
    test_random_runs();
    test_steady_stream();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tagged_scatter_with_duplicate_check_unit verification clean");
    end else begin
      $display("tagged_scatter_with_duplicate_check_unit verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/tsdc_pkg.sv
hw/rtl/tsdc_regs.sv
hw/rtl/tsdc_mem.sv
hw/rtl/tsdc_core.sv
hw/rtl/tagged_scatter_with_duplicate_check_unit.sv
test/tb_tagged_scatter_with_duplicate_check_unit.sv
